### sv/bal_pkg.sv
// Package for the bounded array list: sizes, command codes, beat types and sequencer states.
package bal_pkg;

	localparam int CAPACITY = 8;
	localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = 4;
	localparam int DATA_W   = 32;

	typedef enum logic [2:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_BACK  = 3'd1,
		CMD_INS_POS   = 3'd2,
		CMD_RM_FRONT  = 3'd3,
		CMD_RM_BACK   = 3'd4,
		CMD_RM_POS    = 3'd5
	} bal_cmd_t;

	typedef struct packed {
		logic [2:0]               command;
		logic signed [DATA_W-1:0] element;
		logic [2:0]               position;
	} bal_in_t;

	typedef struct packed {
		logic                     success;
		logic signed [DATA_W-1:0] removed_value;
		logic [CNT_W-1:0]         length;
	} bal_out_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_RESP
	} bal_state_t;

endpackage

### sv/bal_mem.sv
// Entry store: one write port and one read port with registered read data.
module bal_mem #(
	parameter int DEPTH = bal_pkg::CAPACITY,
	parameter int AW    = bal_pkg::AW,
	parameter int W     = bal_pkg::DATA_W
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [W-1:0]  rd_data
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### sv/bounded_array_list_unit.sv
// Top level of the bounded array list: command sequencer, entry shifting and result register.
// A command runs S_IDLE, S_SHIFT, S_RESP; S_SHIFT reads the count - position entries from
// the position on and shifts them through the read and write ports, one entry per cycle;
// a failed command goes from S_IDLE straight to S_RESP. A new command is taken only in
// S_IDLE, after the last has loaded its result; S_RESP waits while a result is stalled.
// Reset clears the sequencer, the count and the result valid; entry contents are not cleared.
module bounded_array_list_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  bal_pkg::bal_in_t  cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output bal_pkg::bal_out_t rsp
);
	import bal_pkg::*;

	bal_state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic              op_ins_q;
	logic              ok_q;
	logic [DATA_W-1:0] elem_q;
	logic [AW-1:0]     pos_q;
	logic [AW-1:0]     rd_addr_q;
	logic [CNT_W-1:0]  rd_left_q;
	logic              first_q;
	logic              pend_s1;
	logic              first_s1;
	logic [AW-1:0]     wr_addr_s1;
	logic [DATA_W-1:0] removed_q;
	logic              rsp_valid_q;
	bal_out_t          rsp_q;

	// Decode of the incoming command.
	logic             dec_ins;
	logic             dec_rm;
	logic [CNT_W-1:0] dec_pos;
	logic             dec_ok;

	logic              accept;
	logic              rsp_load;
	logic              rd_en;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic [DATA_W-1:0] rd_data;
	logic [CNT_W-1:0]  new_count;

	always_comb begin
		dec_ins = 1'b0;
		dec_rm  = 1'b0;
		dec_pos = '0;
		unique case (cmd.command)
			CMD_INS_FRONT: begin
				dec_ins = 1'b1;
			end
			CMD_INS_BACK: begin
				dec_ins = 1'b1;
				dec_pos = count_q;
			end
			CMD_INS_POS: begin
				dec_ins = 1'b1;
				dec_pos = CNT_W'(cmd.position);
			end
			CMD_RM_FRONT: begin
				dec_rm = 1'b1;
			end
			CMD_RM_BACK: begin
				dec_rm  = 1'b1;
				dec_pos = count_q - CNT_W'(1);
			end
			CMD_RM_POS: begin
				dec_rm  = 1'b1;
				dec_pos = CNT_W'(cmd.position);
			end
			default: begin
			end
		endcase
		dec_ok = (dec_ins && (count_q < CNT_W'(CAPACITY)) && (dec_pos <= count_q))
			|| (dec_rm && (count_q != '0) && (dec_pos < count_q));
	end

	assign accept   = (state_q == S_IDLE) && cmd_valid;
	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || !rsp_stall);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					state_d = dec_ok ? S_SHIFT : S_RESP;
				end
			end
			S_SHIFT: begin
				if (rd_left_q == '0) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Shift: a read per cycle; data is written one entry on next cycle or kept if removed.
	assign rd_en = (state_q == S_SHIFT) && (rd_left_q != '0);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wr_addr_s1;
		wr_data = rd_data;
		if (pend_s1 && !first_s1) begin
			wr_en = 1'b1;
		end else if ((state_q == S_RESP) && op_ins_q && ok_q) begin
			wr_en   = 1'b1;
			wr_addr = pos_q;
			wr_data = elem_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_ins_q  <= dec_ins;
			ok_q      <= dec_ok;
			elem_q    <= cmd.element;
			pos_q     <= AW'(dec_pos);
			rd_addr_q <= dec_ins ? AW'(count_q - CNT_W'(1)) : AW'(dec_pos);
			rd_left_q <= dec_ok ? (count_q - dec_pos) : '0;
			first_q   <= dec_rm;
			removed_q <= '0;
		end else if (rd_en) begin
			rd_addr_q <= op_ins_q ? (rd_addr_q - AW'(1)) : (rd_addr_q + AW'(1));
			rd_left_q <= rd_left_q - CNT_W'(1);
			first_q   <= 1'b0;
		end
		if (pend_s1 && first_s1) begin
			removed_q <= rd_data;
		end
		wr_addr_s1 <= op_ins_q ? (rd_addr_q + AW'(1)) : (rd_addr_q - AW'(1));
		first_s1   <= first_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
		end
	end

	bal_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.W     (DATA_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	// Count and result register.
	always_comb begin
		new_count = count_q;
		if (ok_q) begin
			new_count = op_ins_q ? (count_q + CNT_W'(1)) : (count_q - CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				count_q     <= new_count;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.success       <= ok_q;
			rsp_q.removed_value <= (ok_q && !op_ins_q) ? removed_q : '0;
			rsp_q.length        <= new_count;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list count beyond capacity");

	a_count_moves_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_RESP) |=> $stable(count_q))
		else $error("count changed outside result load");

	a_pend_after_shift: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> $past(state_q) == S_SHIFT)
		else $error("shift write pending outside shifting");

	a_fail_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.success |-> rsp_q.removed_value == '0)
		else $error("failed command reports a removed value");

	a_single_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> (new_count == count_q) || (new_count == count_q + CNT_W'(1))
			|| (new_count == count_q - CNT_W'(1)))
		else $error("count moved by more than one entry");

endmodule

### bench/tb_top.sv
// Self-checking bench for the bounded array list: directed table, random command mix, list predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bal_pkg::*;

	// Codes outside the command set, which the block must answer as a failed command.
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	localparam int RANDOM_ITEMS = 1830;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 4000;
	localparam int SHOWN_ERRORS = 40;

	typedef struct {
		bal_in_t  beat;
		bit       typed;
		bal_out_t want;
	} probe_row_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     cmd_valid = 1'b0;
	logic     cmd_stall;
	bal_in_t  cmd       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	bal_out_t rsp;

	logic signed [DATA_W-1:0] list_mem [CAPACITY];
	int         list_len      = 0;
	int         fill_estimate = 0;
	bal_out_t   pending_results [$];
	probe_row_t table_answers [$];
	probe_row_t probe_rows [$];
	int         mismatches    = 0;
	int         rsp_seen      = 0;
	int         quiet_cycles  = 0;
	bit         calm          = 1'b0;

	bounded_array_list_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Applies one command to the predicted list and returns the result it should give.
	function automatic bal_out_t apply_command(input bal_in_t c);
		bal_out_t r;
		int       slot;
		int       i;
		r = '0;
		case (c.command)
			CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
				if (c.command == CMD_INS_FRONT)
					slot = 0;
				else if (c.command == CMD_INS_BACK)
					slot = list_len;
				else
					slot = int'(c.position);
				if (list_len < CAPACITY && slot <= list_len) begin
					for (i = list_len; i > slot; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[slot] = c.element;
					list_len++;
					r.success = 1'b1;
				end
			end
			CMD_RM_FRONT, CMD_RM_BACK, CMD_RM_POS: begin
				if (c.command == CMD_RM_FRONT)
					slot = 0;
				else if (c.command == CMD_RM_BACK)
					slot = list_len - 1;
				else
					slot = int'(c.position);
				if (list_len != 0 && slot >= 0 && slot < list_len) begin
					r.removed_value = list_mem[slot];
					for (i = slot; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i + 1];
					list_len--;
					r.success = 1'b1;
				end
			end
			default: ;
		endcase
		r.length = list_len[CNT_W-1:0];
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Mostly well-formed commands aimed at the live part of the list, with some strays.
	function automatic bal_in_t random_command(input int grow_pct);
		bal_in_t b;
		int      r;
		int      top;
		b.position = 3'($urandom_range(0, 7));
		r = $urandom_range(0, 99);
		if (r < 12) begin
			case ($urandom_range(0, 4))
				0: b.element = 32'sh8000_0000;
				1: b.element = 32'sh7FFF_FFFF;
				2: b.element = -32'sd1;
				3: b.element = 32'sd0;
				default: b.element = 32'sd1;
			endcase
		end else begin
			b.element = $urandom;
		end
		r = $urandom_range(0, 199);
		if (r == 0) begin
			b.command = CMD_SPARE_6;
		end else if (r == 1) begin
			b.command = CMD_SPARE_7;
		end else if ($urandom_range(0, 99) < grow_pct) begin
			case ($urandom_range(0, 2))
				0: b.command = CMD_INS_FRONT;
				1: b.command = CMD_INS_BACK;
				default: b.command = CMD_INS_POS;
			endcase
			top = (fill_estimate < 7) ? fill_estimate : 7;
			if (b.command == CMD_INS_POS && $urandom_range(0, 99) < 85)
				b.position = 3'($urandom_range(0, top));
		end else begin
			case ($urandom_range(0, 2))
				0: b.command = CMD_RM_FRONT;
				1: b.command = CMD_RM_BACK;
				default: b.command = CMD_RM_POS;
			endcase
			if (b.command == CMD_RM_POS && fill_estimate > 0 && $urandom_range(0, 99) < 85)
				b.position = 3'($urandom_range(0, fill_estimate - 1));
		end
		return b;
	endfunction

	task automatic row(input logic [2:0] c, input logic [31:0] e, input int p,
			input bit typed, input bit ok, input logic [31:0] gone, input int len);
		probe_row_t t;
		t.beat.command       = c;
		t.beat.element       = e;
		t.beat.position      = 3'(p);
		t.typed              = typed;
		t.want.success       = ok;
		t.want.removed_value = gone;
		t.want.length        = CNT_W'(len);
		probe_rows.push_back(t);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= SHOWN_ERRORS)
			$display("mismatch: %s at %0t ns, got %0h, expected %0h", what, $time, got, want);
	endtask

	// Offers one beat and returns at the edge where it is taken; valid stays up for a
	// following beat unless a gap is drawn.
	task automatic offer_beat(input probe_row_t t);
		int gap;
		gap = idle_len();
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		table_answers.push_back(t);
		cmd       <= t.beat;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall !== 1'b0)
			@(posedge clk);
		// Rough length used only to aim the random positions.
		case (t.beat.command)
			CMD_INS_FRONT, CMD_INS_BACK:
				if (fill_estimate < CAPACITY) fill_estimate++;
			CMD_INS_POS:
				if (fill_estimate < CAPACITY && t.beat.position <= fill_estimate) fill_estimate++;
			CMD_RM_FRONT, CMD_RM_BACK:
				if (fill_estimate > 0) fill_estimate--;
			CMD_RM_POS:
				if (t.beat.position < fill_estimate) fill_estimate--;
			default: ;
		endcase
	endtask

	initial begin : stimulus
		probe_row_t t;
		int         n;
		int         grow_pct;
		// Empty list: every removal fails, and so does an insert beyond the end.
		row(CMD_RM_FRONT,  32'hDEAD_BEEF, 0, 1, 0, 32'h0, 0);
		row(CMD_RM_BACK,   32'hFFFF_FFFF, 7, 1, 0, 32'h0, 0);
		row(CMD_RM_POS,    32'h0000_0000, 0, 1, 0, 32'h0, 0);
		row(CMD_INS_POS,   32'h0000_0001, 1, 1, 0, 32'h0, 0);
		row(CMD_INS_POS,   32'h7FFF_FFFF, 0, 1, 1, 32'h0, 1);
		row(CMD_INS_FRONT, 32'h8000_0000, 7, 1, 1, 32'h0, 2);
		row(CMD_INS_BACK,  32'hFFFF_FFFF, 5, 1, 1, 32'h0, 3);
		row(CMD_INS_POS,   32'h0000_0000, 3, 1, 1, 32'h0, 4);
		row(CMD_INS_POS,   32'h2222_2222, 5, 1, 0, 32'h0, 4);
		row(CMD_SPARE_6,   32'h3333_3333, 0, 1, 0, 32'h0, 4);
		row(CMD_SPARE_7,   32'hFFFF_FFFF, 7, 1, 0, 32'h0, 4);
		row(CMD_INS_POS,   32'h5555_5555, 2, 0, 0, 32'h0, 0);
		row(CMD_INS_FRONT, 32'hAAAA_AAAA, 2, 0, 0, 32'h0, 0);
		row(CMD_INS_BACK,  32'h0000_0001, 0, 0, 0, 32'h0, 0);
		row(CMD_INS_POS,   32'h0000_0002, 7, 1, 1, 32'h0, 8);
		// Full list: every insert fails.
		row(CMD_INS_FRONT, 32'h4444_4444, 0, 1, 0, 32'h0, 8);
		row(CMD_INS_POS,   32'h6666_6666, 0, 1, 0, 32'h0, 8);
		row(CMD_INS_BACK,  32'h7777_7777, 1, 1, 0, 32'h0, 8);
		row(CMD_RM_POS,    32'hFFFF_FFFF, 7, 1, 1, 32'h2, 7);
		row(CMD_RM_POS,    32'h0000_0000, 7, 1, 0, 32'h0, 7);
		row(CMD_RM_FRONT,  32'h0000_0000, 0, 1, 1, 32'hAAAA_AAAA, 6);
		row(CMD_RM_BACK,   32'h0000_0000, 3, 1, 1, 32'h1, 5);
		row(CMD_RM_POS,    32'h0000_0000, 1, 0, 0, 32'h0, 0);
		row(CMD_RM_POS,    32'h0000_0000, 0, 0, 0, 32'h0, 0);
		row(CMD_RM_BACK,   32'h0000_0000, 0, 0, 0, 32'h0, 0);

		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (probe_rows[i])
			offer_beat(probe_rows[i]);

		grow_pct = 50;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 400 && n < 560) || (n >= 1300 && n < 1400);
			if (n % 40 == 0) begin
				case ($urandom_range(0, 3))
					0: grow_pct = 80;
					1: grow_pct = 20;
					default: grow_pct = 50;
				endcase
			end
			t.beat  = random_command(grow_pct);
			t.typed = 1'b0;
			t.want  = '0;
			offer_beat(t);
		end
		calm = 1'b0;
		cmd_valid <= 1'b0;

		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (CAPACITY + 4) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Result side: random stalls, plus two long hold-offs that back the block up into its input.
	initial begin : result_side
		int k;
		int next_hold;
		next_hold = 150;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			k = idle_len();
			if (rsp_seen >= next_hold) begin
				k = HOLD_CYCLES;
				next_hold += 950;
			end
			if (k != 0) begin
				rsp_stall <= 1'b1;
				repeat (k) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	always @(posedge clk) begin : scoreboard
		bal_out_t   want;
		probe_row_t note;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				rsp_seen++;
				if (pending_results.size() == 0) begin
					report_mismatch("result beat with nothing pending, length",
						32'(rsp.length), '0);
				end else begin
					want = pending_results.pop_front();
					if (rsp.success !== want.success)
						report_mismatch("success", 32'(rsp.success), 32'(want.success));
					if (rsp.removed_value !== want.removed_value)
						report_mismatch("removed_value", rsp.removed_value, want.removed_value);
					if (rsp.length !== want.length)
						report_mismatch("length", 32'(rsp.length), 32'(want.length));
				end
			end
			if (cmd_valid && !cmd_stall) begin
				want = apply_command(cmd);
				if (table_answers.size() != 0) begin
					note = table_answers.pop_front();
					if (note.typed)
						want = note.want;
				end
				pending_results.push_back(want);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule
